// ===== rtl/tar_member_extractor_defines.svh =====
// Assertion macros shared by the tar member extractor RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef TAR_MEMBER_EXTRACTOR_DEFINES_SVH
`define TAR_MEMBER_EXTRACTOR_DEFINES_SVH

// Checked assertion, disabled while reset is asserted.
`define TME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked assertion, also evaluated during reset.
`define TME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/tme_pkg.sv =====
// Package for the tar member extractor: result kinds, parser phases, field
// positions and the result types passed between the parser and the queue.
// No dependencies.
package tme_pkg;

  localparam int unsigned BlockPosW   = 9;
  localparam int unsigned SizeW       = 64;
  localparam int unsigned ResultDepth = 4;

  localparam logic [BlockPosW-1:0] NameBytes   = 9'd100;
  localparam logic [BlockPosW-1:0] SizeFirst   = 9'd124;
  localparam logic [BlockPosW-1:0] SizeEnd     = 9'd136;
  localparam logic [BlockPosW-1:0] TypeflagPos = 9'd156;
  localparam logic [BlockPosW-1:0] LastPos     = 9'd511;
  localparam logic [BlockPosW:0]   BlockBytes  = 10'd512;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;

  typedef enum logic [2:0] {
    KIND_NAME       = 3'd0,
    KIND_KEPT       = 3'd1,
    KIND_SKIPPED    = 3'd2,
    KIND_DATA       = 3'd3,
    KIND_END        = 3'd4,
    KIND_TRUNC      = 3'd5,
    KIND_INCOMPLETE = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       byte_value;
    logic [SizeW-1:0] member_size;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    res0;
    result_t    res1;
  } res_push_t;

endpackage

// ===== rtl/tar_member_extractor.sv =====
// Top level of the tar member extractor: byte parser followed by a result
// queue. Depends on tme_pkg, tme_parser and tme_result_fifo.
//
// Channel   Direction  tdata                                  tuser  tlast
// s_axis    in         [7:0] archive_byte                     -      final_byte
// m_axis    out        [7:0] byte_value, [71:8] member_size   kind   last_of_run
//
// One input byte is accepted per cycle; its results are written into a
// four-entry queue the same cycle and can leave on the next edge.
// A byte gives at most two results, so s_axis_tready is high while the queue
// holds at least two free entries; output stalls stop input once fewer are free.
// Reset clears the parser to the start of a header and empties the queue.
module tar_member_extractor #(
  parameter int unsigned ResultDepth = tme_pkg::ResultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] archive_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] byte_value, [71:8] member_size
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last_of_run
);

  tme_pkg::res_push_t push;
  tme_pkg::result_t   head;
  logic               room;
  logic               accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  tme_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .archive_byte_i (s_axis_tdata),
    .final_byte_i   (s_axis_tlast),
    .push_o         (push)
  );

  tme_result_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {head.member_size, head.byte_value};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last_of_run;

endmodule

// ===== rtl/tme_result_fifo.sv =====
// Small result queue for the tar member extractor: takes up to two results
// per cycle and hands out one per transaction. Depends on tme_pkg.
`include "tar_member_extractor_defines.svh"

module tme_result_fifo #(
  parameter int unsigned Depth = tme_pkg::ResultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tme_pkg::res_push_t push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output tme_pkg::result_t  head_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tme_pkg::result_t mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  function automatic logic [IdxW-1:0] ptr_inc(input logic [IdxW-1:0] p);
    ptr_inc = (p == IdxW'(Depth - 1)) ? '0 : p + IdxW'(1);
  endfunction

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= CntW'(Depth - 2));
  assign head_o  = mem_q[rd_ptr_q];
  assign wr_next = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i.cnt == 2'd1) begin
      wr_ptr_d = wr_next;
    end else if (push_i.cnt == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_next);
    end
    if (pop) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    count_d = count_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

  `TME_ASSERT(a_count_bound, count_q <= CntW'(Depth), "result queue over capacity")
  `TME_ASSERT(a_push_room, (push_i.cnt != 2'd0) |-> room_o, "push without room")
  `TME_ASSERT(a_count_track, 1'b1 |=> count_q == $past(count_q) + CntW'($past(push_i.cnt)) - CntW'($past(pop)), "queue count mismatch")

endmodule

// ===== rtl/tme_parser.sv =====
// Byte parser of the tar member extractor: walks header, data and padding
// blocks and produces up to two results per byte. Depends on tme_pkg.
`include "tar_member_extractor_defines.svh"

module tme_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         archive_byte_i,
  input  logic               final_byte_i,
  output tme_pkg::res_push_t push_o
);

  tme_pkg::phase_e                   phase_q, phase_d;
  logic [tme_pkg::BlockPosW-1:0]     pos_q, pos_d;
  logic                              name_open_q, name_open_d;
  logic                              size_open_q, size_open_d;
  logic [tme_pkg::SizeW-1:0]         acc_q, acc_d;
  logic                              kept_q, kept_d;
  logic [tme_pkg::SizeW-1:0]         left_q, left_d;
  logic [tme_pkg::BlockPosW-1:0]     pad_q, pad_d;

  always_comb begin
    logic                          have0;
    logic                          close;
    tme_pkg::kind_e                close_kind;
    tme_pkg::result_t              r0;
    tme_pkg::result_t              rc;
    logic [tme_pkg::BlockPosW-1:0] pad_new;
    logic [tme_pkg::SizeW-1:0]     left_new;
    logic [7:0]                    b;

    b          = archive_byte_i;
    have0      = 1'b0;
    close      = 1'b0;
    close_kind = tme_pkg::KIND_END;
    r0         = '0;
    rc         = '0;
    pad_new    = '0;
    left_new   = '0;

    phase_d     = phase_q;
    pos_d       = pos_q;
    name_open_d = name_open_q;
    size_open_d = size_open_q;
    acc_d       = acc_q;
    kept_d      = kept_q;
    left_d      = left_q;
    pad_d       = pad_q;

    case (phase_q)
      tme_pkg::PH_HEADER: begin
        if (pos_q == '0 && b == tme_pkg::CharNul) begin
          phase_d = tme_pkg::PH_DONE;
          close   = final_byte_i;
        end else begin
          if (pos_q < tme_pkg::NameBytes && name_open_q) begin
            if (b == tme_pkg::CharNul) begin
              name_open_d = 1'b0;
            end else begin
              have0         = 1'b1;
              r0.kind       = tme_pkg::KIND_NAME;
              r0.byte_value = b;
            end
          end
          if (pos_q >= tme_pkg::SizeFirst && pos_q < tme_pkg::SizeEnd && size_open_q) begin
            if (b == tme_pkg::CharSpace || b == tme_pkg::CharNul) begin
              size_open_d = 1'b0;
            end else begin
              acc_d = {acc_q[tme_pkg::SizeW-4:0], 3'b000} + {56'd0, b}
                      - {56'd0, tme_pkg::CharZero};
            end
          end
          if (pos_q == tme_pkg::TypeflagPos) begin
            kept_d = (b == tme_pkg::CharZero) || (b == tme_pkg::CharNul);
          end
          if (pos_q == tme_pkg::LastPos) begin
            have0          = 1'b1;
            r0.kind        = kept_q ? tme_pkg::KIND_KEPT : tme_pkg::KIND_SKIPPED;
            r0.member_size = acc_q;
            pad_new        = tme_pkg::BlockPosW'(tme_pkg::BlockBytes - {1'b0, acc_q[8:0]});
            left_d         = acc_q;
            pad_d          = pad_new;
            pos_d          = '0;
            name_open_d    = 1'b1;
            size_open_d    = 1'b1;
            acc_d          = '0;
            if (acc_q != '0) begin
              phase_d = tme_pkg::PH_DATA;
            end else if (pad_new != '0) begin
              phase_d = tme_pkg::PH_PAD;
            end else begin
              phase_d = tme_pkg::PH_HEADER;
            end
            close      = final_byte_i;
            close_kind = (kept_q && acc_q != '0) ? tme_pkg::KIND_TRUNC : tme_pkg::KIND_END;
          end else begin
            pos_d      = pos_q + tme_pkg::BlockPosW'(1);
            close      = final_byte_i;
            close_kind = tme_pkg::KIND_INCOMPLETE;
          end
        end
      end
      tme_pkg::PH_DATA: begin
        if (kept_q) begin
          have0         = 1'b1;
          r0.kind       = tme_pkg::KIND_DATA;
          r0.byte_value = b;
        end
        left_new = left_q - tme_pkg::SizeW'(1);
        left_d   = left_new;
        if (left_new == '0) begin
          if (pad_q != '0) begin
            phase_d = tme_pkg::PH_PAD;
          end else begin
            phase_d     = tme_pkg::PH_HEADER;
            pos_d       = '0;
            name_open_d = 1'b1;
            size_open_d = 1'b1;
            acc_d       = '0;
          end
        end
        close      = final_byte_i;
        close_kind = (kept_q && left_new != '0) ? tme_pkg::KIND_TRUNC : tme_pkg::KIND_END;
      end
      tme_pkg::PH_PAD: begin
        pad_new = (pad_q != '0) ? pad_q - tme_pkg::BlockPosW'(1) : pad_q;
        pad_d   = pad_new;
        if (pad_new == '0) begin
          phase_d     = tme_pkg::PH_HEADER;
          pos_d       = '0;
          name_open_d = 1'b1;
          size_open_d = 1'b1;
          acc_d       = '0;
        end
        close = final_byte_i;
      end
      default: begin
        close = final_byte_i;
      end
    endcase

    if (close) begin
      phase_d     = tme_pkg::PH_HEADER;
      pos_d       = '0;
      name_open_d = 1'b1;
      size_open_d = 1'b1;
      acc_d       = '0;
      kept_d      = 1'b0;
      left_d      = '0;
      pad_d       = '0;
    end

    rc.kind        = close_kind;
    rc.last_of_run = 1'b1;

    push_o = '0;
    if (accept_i) begin
      if (have0) begin
        push_o.res0 = r0;
        push_o.res1 = rc;
        push_o.cnt  = close ? 2'd2 : 2'd1;
      end else if (close) begin
        push_o.res0 = rc;
        push_o.cnt  = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tme_pkg::PH_HEADER;
      pos_q       <= '0;
      name_open_q <= 1'b1;
      size_open_q <= 1'b1;
      acc_q       <= '0;
      kept_q      <= 1'b0;
      left_q      <= '0;
      pad_q       <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      name_open_q <= name_open_d;
      size_open_q <= size_open_d;
      acc_q       <= acc_d;
      kept_q      <= kept_d;
      left_q      <= left_d;
      pad_q       <= pad_d;
    end
  end

  `TME_ASSERT(a_close_resets, accept_i && final_byte_i |=> phase_q == tme_pkg::PH_HEADER && pos_q == '0 && !kept_q && left_q == '0, "state not reset after final byte")
  `TME_ASSERT(a_second_closes, push_o.cnt == 2'd2 |-> push_o.res1.last_of_run && !push_o.res0.last_of_run, "second result is not the closing one")
  `TME_ASSERT(a_data_left, phase_q == tme_pkg::PH_DATA |-> left_q != '0, "data phase with no bytes left")
  `TME_ASSERT(a_pad_left, phase_q == tme_pkg::PH_PAD |-> pad_q != '0, "padding phase with no bytes left")

endmodule

// ===== tb/tar_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the tar member extractor testbench: follows the archive parse
// for every accepted input byte and compares each output transaction with the
// oldest expected result. Depends on tme_pkg.
module tar_result_checker
  import tme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_final_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [71:0] out_data_i,
  input  logic [2:0]  out_kind_i,
  input  logic        out_last_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  result_t expected_results[$];
  int      mismatch_count = 0;
  int      pending_count = 0;

  phase_e         arc_phase;
  logic [8:0]     hdr_pos;
  bit             name_on;
  bit             size_on;
  logic [63:0]    size_acc;
  bit             kept;
  logic [63:0]    data_left;
  logic [8:0]     pad_left;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = pending_count;

  function automatic void open_header();
    arc_phase = PH_HEADER;
    hdr_pos   = '0;
    name_on   = 1'b1;
    size_on   = 1'b1;
    size_acc  = '0;
  endfunction

  function automatic void clear_parser();
    open_header();
    kept      = 1'b0;
    data_left = '0;
    pad_left  = '0;
  endfunction

  function automatic void finish_member();
    if (pad_left != '0) begin
      arc_phase = PH_PAD;
    end else begin
      open_header();
    end
  endfunction

  function automatic void expect_result(kind_e k, logic [7:0] b, logic [63:0] sz, logic last);
    result_t r;
    r.kind        = k;
    r.byte_value  = b;
    r.member_size = sz;
    r.last_of_run = last;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void parse_archive_byte(logic [7:0] b, logic is_last);
    bit          closing;
    kind_e       close_kind;
    logic [63:0] sz;
    closing    = 1'b0;
    close_kind = KIND_END;
    case (arc_phase)
      PH_HEADER: begin
        if (hdr_pos == '0 && b == CharNul) begin
          arc_phase = PH_DONE;
          closing   = is_last;
        end else begin
          if (hdr_pos < NameBytes && name_on) begin
            if (b == CharNul) begin
              name_on = 1'b0;
            end else begin
              expect_result(KIND_NAME, b, '0, 1'b0);
            end
          end
          if (hdr_pos >= SizeFirst && hdr_pos < SizeEnd && size_on) begin
            if (b == CharSpace || b == CharNul) begin
              size_on = 1'b0;
            end else begin
              size_acc = (size_acc << 3) + 64'(b) - 64'(CharZero);
            end
          end
          if (hdr_pos == TypeflagPos) begin
            kept = (b == CharZero || b == CharNul);
          end
          if (hdr_pos == LastPos) begin
            sz = size_acc;
            expect_result(kept ? KIND_KEPT : KIND_SKIPPED, 8'h00, sz, 1'b0);
            data_left = sz;
            pad_left  = 9'd0 - sz[8:0];
            if (data_left != '0) begin
              arc_phase = PH_DATA;
            end else begin
              finish_member();
            end
            closing = is_last;
            if (kept && sz != '0) close_kind = KIND_TRUNC;
          end else begin
            hdr_pos    = hdr_pos + 9'd1;
            closing    = is_last;
            close_kind = KIND_INCOMPLETE;
          end
        end
      end
      PH_DATA: begin
        if (kept) expect_result(KIND_DATA, b, '0, 1'b0);
        data_left = data_left - 64'd1;
        if (data_left == '0) finish_member();
        closing = is_last;
        if (kept && data_left != '0) close_kind = KIND_TRUNC;
      end
      PH_PAD: begin
        if (pad_left != '0) pad_left = pad_left - 9'd1;
        if (pad_left == '0) open_header();
        closing = is_last;
      end
      default: begin
        closing = is_last;
      end
    endcase
    if (closing) begin
      expect_result(close_kind, 8'h00, '0, 1'b1);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction, kind %0d", out_kind_i));
      return;
    end
    want = expected_results.pop_front();
    if (out_kind_i !== want.kind) begin
      report_mismatch($sformatf("kind %0d, expected %0d", out_kind_i, want.kind));
    end
    if (out_data_i[7:0] !== want.byte_value) begin
      report_mismatch($sformatf("byte_value %02h, expected %02h", out_data_i[7:0],
                                want.byte_value));
    end
    if (out_data_i[71:8] !== want.member_size) begin
      report_mismatch($sformatf("member_size %016h, expected %016h", out_data_i[71:8],
                                want.member_size));
    end
    if (out_last_i !== want.last_of_run) begin
      report_mismatch($sformatf("last_of_run %b, expected %b", out_last_i, want.last_of_run));
    end
  endtask

  initial clear_parser();

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_parser();
      expected_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) parse_archive_byte(in_byte_i, in_final_i);
      if (out_valid_i && out_ready_i) check_result();
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for tar_member_extractor: sends short directed tar archives with
// random contents, random idles and output stalls, and prints the verdict.
// Depends on tme_pkg, tar_result_checker and the RTL.
module tb_top;
  import tme_pkg::*;

  localparam int CycleLimit  = 20000;
  localparam int DrainCycles = 20;
  localparam int OpenSize    = 2048;

  typedef enum int {
    FMT_OCTAL_NUL,
    FMT_SHORT_SPACE,
    FMT_FULL_DIGITS,
    FMT_NOISE
  } size_fmt_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int         mismatch_count;
  int         pending_results;
  int         cycle_count = 0;
  bit         calm = 1'b0;
  logic [7:0] arc_bytes[$];

  tar_member_extractor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  tar_result_checker result_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_byte_i        (s_axis_tdata),
    .in_final_i       (s_axis_tlast),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_kind_i       (m_axis_tuser),
    .out_last_i       (m_axis_tlast),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready = 1'b1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= 30);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic void append_byte(input logic [7:0] b);
    arc_bytes.insert(arc_bytes.size(), b);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (!calm && $urandom_range(99) < 30) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_archive();
    int i;
    for (i = 0; i < arc_bytes.size(); i++) begin
      send_byte(arc_bytes[i], i == arc_bytes.size() - 1);
    end
    s_axis_tvalid = 1'b0;
  endtask

  task automatic cut_archive(input int keep);
    if (keep < arc_bytes.size()) arc_bytes = arc_bytes[0:keep-1];
  endtask

  task automatic add_member(input int name_len, input logic [63:0] size, input logic [7:0] tflag,
                            input size_fmt_e fmt, output bit open_ended);
    logic [7:0] size_field[12];
    logic [7:0] b;
    int         i;
    int         digits;
    int         pad;
    for (i = 0; i < 12; i++) size_field[i] = 8'($urandom_range(0, 255));
    case (fmt)
      FMT_OCTAL_NUL: begin
        for (i = 0; i < 11; i++) size_field[i] = CharZero + 8'((size >> (3 * (10 - i))) & 64'd7);
        size_field[11] = CharNul;
      end
      FMT_SHORT_SPACE: begin
        digits = 1;
        while (digits < 11 && (size >> (3 * digits)) != 0) digits++;
        for (i = 0; i < digits; i++) begin
          size_field[i] = CharZero + 8'((size >> (3 * (digits - 1 - i))) & 64'd7);
        end
        size_field[digits] = CharSpace;
      end
      FMT_FULL_DIGITS: begin
        for (i = 0; i < 12; i++) size_field[i] = CharZero + 8'((size >> (3 * (11 - i))) & 64'd7);
      end
      default: begin
      end
    endcase
    for (i = 0; i < 512; i++) begin
      if (i < name_len) begin
        b = 8'($urandom_range(1, 255));
      end else if (i == name_len && i < 100) begin
        b = CharNul;
      end else if (i >= 124 && i < 136) begin
        b = size_field[i - 124];
      end else if (i == 156) begin
        b = tflag;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      append_byte(b);
    end
    open_ended = (fmt == FMT_NOISE) || (size > OpenSize);
    if (open_ended) begin
      repeat ($urandom_range(1, 40)) append_byte(8'($urandom_range(0, 255)));
    end else begin
      pad = (512 - int'(size % 512)) % 512;
      repeat (int'(size) + pad) append_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    bit open_ended;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    arc_bytes = '{CharNul};
    send_archive();
    arc_bytes = '{CharNul, 8'hFF, CharNul, 8'h5A, 8'hA5};
    send_archive();
    arc_bytes = '{8'hFF, 8'h01, 8'h80};
    send_archive();

    calm = 1'b1;
    arc_bytes.delete();
    add_member(100, 2, CharZero, FMT_OCTAL_NUL, open_ended);
    cut_archive(512 + 1);
    send_archive();
    calm = 1'b0;

    wait (pending_results == 0);
    @(negedge clk_i);

    arc_bytes.delete();
    add_member(5, 1, "5", FMT_SHORT_SPACE, open_ended);
    cut_archive(512 + 1 + 2);
    send_archive();

    s_axis_tvalid = 1'b0;
    wait (pending_results == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
